// ----- rtl/ten_bit_pixel_pack_unpack_unit_defines.svh -----
// ----------------------------------------------------------------------------
// ten-bit pixel pack/unpack assertion macros
// shared assertion forms for the pack/unpack unit
// ----------------------------------------------------------------------------
`ifndef TEN_BIT_PIXEL_PACK_UNPACK_UNIT_DEFINES_SVH
`define TEN_BIT_PIXEL_PACK_UNPACK_UNIT_DEFINES_SVH

// same-cycle implication, held off during reset
`define TBPU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define TBPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tbpu_pkg.sv -----
// ----------------------------------------------------------------------------
// tbpu_pkg
// shared constants, register indexes and queue entry type
// ----------------------------------------------------------------------------
package tbpu_pkg;

    localparam int unsigned DEFAULT_MAX_LINE_SAMPLES = 8192;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_PACK_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_SAMPLES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WORDS     = 2'd2;

    // field and state widths
    localparam int unsigned SAMPLE_W    = 10;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned SAMPLES_W   = 14;
    localparam int unsigned WORDS_W     = 12;
    localparam int unsigned HELD_W      = 17;
    localparam int unsigned ACC_W       = 48;
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned IDX_W       = 2;
    localparam int unsigned BITS_W      = MAX_RESULTS * SAMPLE_W;

    localparam logic [SAMPLES_W-1:0] LINE_SAMPLES_RST = 14'd8192;
    localparam logic [WORDS_W-1:0]   LINE_WORDS_RST   = 12'd3200;

    localparam int unsigned QUEUE_DEPTH = 4;

    // one classified item: up to four samples or one packed word
    typedef struct packed {
        logic              is_word;
        logic [CNT_W-1:0]  count;
        logic [BITS_W-1:0] bits;
    } t_job;

endpackage

// ----- rtl/tbpu_front.sv -----
// ----------------------------------------------------------------------------
// tbpu_front
// accepts items, keeps the bit accumulator and line counters, queues results
// ----------------------------------------------------------------------------
`include "ten_bit_pixel_pack_unpack_unit_defines.svh"

module tbpu_front
    import tbpu_pkg::*;
#(
    parameter int unsigned MAX_LINE_SAMPLES = DEFAULT_MAX_LINE_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [WORD_W-1:0]     i_s_tdata,
    input  logic                  i_s_tlast,
    input  logic                  i_full,
    output logic                  o_push,
    output t_job                  o_job
);

    // line_samples never exceeds its own field range, so capping there is exact
    localparam int unsigned SampleFieldMax = (1 << SAMPLES_W) - 1;
    localparam int unsigned LimitCapInt    = (MAX_LINE_SAMPLES < SampleFieldMax) ?
                                             MAX_LINE_SAMPLES : SampleFieldMax;
    localparam logic [SAMPLES_W-1:0] LIMIT_CAP = SAMPLES_W'(LimitCapInt);

    logic                 r_dir,          n_dir;
    logic [SAMPLES_W-1:0] r_line_samples, n_line_samples;
    logic [WORDS_W-1:0]   r_line_words,   n_line_words;
    logic [ACC_W-1:0]     r_acc,          n_acc;
    logic [HELD_W-1:0]    r_held,         n_held;
    logic [SAMPLES_W-1:0] r_sc,           n_sc;
    logic [WORDS_W-1:0]   r_wc,           n_wc;

    logic [SAMPLES_W-1:0] limit;
    logic                 line_open;
    logic                 accept;

    logic [ACC_W-1:0]       u_acc;
    logic [HELD_W-1:0]      u_held;
    logic [MAX_RESULTS-1:0] u_ok;
    logic [CNT_W-1:0]       u_k;
    logic [ACC_W-1:0]       u_acc_next;
    logic [HELD_W-1:0]      u_held_next;

    logic [ACC_W-1:0]  p_acc;
    logic [HELD_W-1:0] p_held;
    logic              p_emit;

    assign limit      = (r_line_samples < LIMIT_CAP) ? r_line_samples : LIMIT_CAP;
    assign line_open  = (r_sc < limit) && (r_wc < r_line_words);
    assign o_s_tready = !i_full;
    assign accept     = i_s_tvalid && o_s_tready;

    // unpack: append the word above the held bits, take whole samples
    assign u_acc  = r_acc | (ACC_W'(i_s_tdata) << r_held[3:0]);
    assign u_held = r_held + HELD_W'(WORD_W);

    always_comb begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            u_ok[j] = (u_held >= HELD_W'(SAMPLE_W * (j + 1))) &&
                      (({1'b0, r_sc} + (SAMPLES_W + 1)'(j)) < {1'b0, limit});
        end
    end

    // both conditions are monotone in j, so the mask is a prefix
    always_comb begin
        unique case (u_ok)
            4'b0001: u_k = 3'd1;
            4'b0011: u_k = 3'd2;
            4'b0111: u_k = 3'd3;
            4'b1111: u_k = 3'd4;
            default: u_k = 3'd0;
        endcase
    end

    always_comb begin
        unique case (u_k)
            3'd1: begin
                u_acc_next  = u_acc >> SAMPLE_W;
                u_held_next = u_held - HELD_W'(SAMPLE_W);
            end
            3'd2: begin
                u_acc_next  = u_acc >> (2 * SAMPLE_W);
                u_held_next = u_held - HELD_W'(2 * SAMPLE_W);
            end
            3'd3: begin
                u_acc_next  = u_acc >> (3 * SAMPLE_W);
                u_held_next = u_held - HELD_W'(3 * SAMPLE_W);
            end
            3'd4: begin
                u_acc_next  = u_acc >> (4 * SAMPLE_W);
                u_held_next = u_held - HELD_W'(4 * SAMPLE_W);
            end
            default: begin
                u_acc_next  = u_acc;
                u_held_next = u_held;
            end
        endcase
    end

    // pack: append ten sample bits, a word leaves once 32 bits are held
    assign p_acc  = r_acc | (ACC_W'(i_s_tdata[SAMPLE_W-1:0]) << r_held[4:0]);
    assign p_held = r_held + HELD_W'(SAMPLE_W);
    assign p_emit = (p_held >= HELD_W'(WORD_W));

    always_comb begin
        o_job.is_word = r_dir;
        if (r_dir) begin
            o_job.count = CNT_W'(1);
            o_job.bits  = BITS_W'(p_acc[WORD_W-1:0]);
        end else begin
            o_job.count = u_k;
            o_job.bits  = u_acc[BITS_W-1:0];
        end
    end

    assign o_push = accept && line_open && (r_dir ? p_emit : (u_k != 3'd0));

    always_comb begin
        n_dir          = r_dir;
        n_line_samples = r_line_samples;
        n_line_words   = r_line_words;
        n_acc          = r_acc;
        n_held         = r_held;
        n_sc           = r_sc;
        n_wc           = r_wc;
        if (accept) begin
            if (line_open) begin
                if (r_dir) begin
                    n_acc  = p_emit ? (p_acc >> WORD_W) : p_acc;
                    n_held = p_emit ? (p_held - HELD_W'(WORD_W)) : p_held;
                    n_sc   = r_sc + 1'b1;
                    n_wc   = p_emit ? (r_wc + 1'b1) : r_wc;
                end else begin
                    n_acc  = u_acc_next;
                    n_held = u_held_next;
                    n_sc   = r_sc + SAMPLES_W'(u_k);
                    n_wc   = r_wc + 1'b1;
                end
            end
            // end of line drops held bits and restarts both counts
            if (i_s_tlast) begin
                n_acc  = '0;
                n_held = '0;
                n_sc   = '0;
                n_wc   = '0;
            end
        end
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PACK_DIRECTION: begin
                    n_dir  = i_cfg_data[0];
                    n_acc  = '0;
                    n_held = '0;
                    n_sc   = '0;
                    n_wc   = '0;
                end
                CFG_LINE_SAMPLES: n_line_samples = i_cfg_data;
                CFG_LINE_WORDS:   n_line_words   = i_cfg_data[WORDS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir          <= 1'b0;
            r_line_samples <= LINE_SAMPLES_RST;
            r_line_words   <= LINE_WORDS_RST;
            r_acc          <= '0;
            r_held         <= '0;
            r_sc           <= '0;
            r_wc           <= '0;
        end else begin
            r_dir          <= n_dir;
            r_line_samples <= n_line_samples;
            r_line_words   <= n_line_words;
            r_acc          <= n_acc;
            r_held         <= n_held;
            r_sc           <= n_sc;
            r_wc           <= n_wc;
        end
    end

    `TBPU_ASSERT_IMPL(a_pack_held_below_word, i_clk, i_rst_n, r_dir, r_held < HELD_W'(WORD_W), "pack mode holds a full word")
    `TBPU_ASSERT_IMPL(a_push_count_range, i_clk, i_rst_n, o_push, (o_job.count != 3'd0) && (o_job.count <= CNT_W'(MAX_RESULTS)), "queued item with bad result count")
    `TBPU_ASSERT_NEXT(a_line_end_clears, i_clk, i_rst_n, accept && i_s_tlast, (r_held == '0) && (r_sc == '0) && (r_wc == '0), "line end did not clear line state")

endmodule

// ----- rtl/tbpu_queue.sv -----
// ----------------------------------------------------------------------------
// tbpu_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
`include "ten_bit_pixel_pack_unpack_unit_defines.svh"

module tbpu_queue
    import tbpu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_Q-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_Q'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : (r_wr_ptr + 1'b1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : (r_rd_ptr + 1'b1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `TBPU_ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `TBPU_ASSERT_IMPL(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `TBPU_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "queue count did not rise")

endmodule

// ----- rtl/tbpu_back.sv -----
// ----------------------------------------------------------------------------
// tbpu_back
// walks each queued item, one result per ready cycle into the output register
// ----------------------------------------------------------------------------
module tbpu_back
    import tbpu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_job              i_head,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [WORD_W-1:0] o_m_tdata,
    output logic              o_m_tlast
);

    logic              r_valid, n_valid;
    logic [IDX_W-1:0]  r_idx,   n_idx;
    logic [WORD_W-1:0] r_data;
    logic              r_last;

    logic              load;
    logic              is_last;
    logic [WORD_W-1:0] sel_data;

    assign load    = i_valid && (!r_valid || i_m_tready);
    assign is_last = (({1'b0, r_idx} + 1'b1) == i_head.count);
    assign o_pop   = load && is_last;

    always_comb begin
        if (i_head.is_word) begin
            sel_data = i_head.bits[WORD_W-1:0];
        end else begin
            sel_data = WORD_W'(i_head.bits[r_idx * SAMPLE_W +: SAMPLE_W]);
        end
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = is_last ? '0 : (r_idx + 1'b1);
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= sel_data;
            r_last <= is_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;

endmodule

// ----- rtl/ten_bit_pixel_pack_unpack_unit.sv -----
// ----------------------------------------------------------------------------
// ten_bit_pixel_pack_unpack_unit
// 10-bit lsb-first packed words <-> 32-bit sample containers
// ----------------------------------------------------------------------------
// usage:
//   the config channel (index, data) sets direction (0 unpack, 1 pack),
//   samples per line and words per line; it is always ready. the user must
//   write it only while the unit is idle (unchecked). a direction write
//   starts a fresh line. the slave stream takes one item per transfer:
//   a packed word when unpacking, a sample in the low bits when packing;
//   tlast ends a line. the master stream gives samples zero-extended to 32
//   bits (unpack) or finished packed words (pack); tlast marks the final
//   result of an item.
// timing:
//   the back end sends one result per cycle while the receiver is ready,
//   from a four-entry queue; a word unpacks to up to four samples. the
//   slave side stays ready while the queue has room.
// reset and stall:
//   synchronous active-low reset clears the line state, the queue and the
//   output valid flag and loads the register defaults. a stalled receiver
//   holds the output register; the queue fills and then drops tready.
// ----------------------------------------------------------------------------
module ten_bit_pixel_pack_unpack_unit
    import tbpu_pkg::*;
#(
    parameter int unsigned MAX_LINE_SAMPLES = DEFAULT_MAX_LINE_SAMPLES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [WORD_W-1:0]     s_axis_tdata,  // [31:0] in_data
    input  logic                  s_axis_tlast,  // line_end
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [WORD_W-1:0]     m_axis_tdata,  // [31:0] out_value
    output logic                  m_axis_tlast   // last_of_run
);

    // front to queue
    logic q_push;
    t_job q_job;
    logic q_full;

    // queue to back
    logic q_valid;
    t_job q_head;
    logic q_pop;

    // registers never back-pressure
    assign o_cfg_ready = 1'b1;

    // accumulator, line counters and result classification
    tbpu_front #(
        .MAX_LINE_SAMPLES (MAX_LINE_SAMPLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .o_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tlast   (s_axis_tlast),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_job       (q_job)
    );

    // decouples intake from the output, one result per cycle while it is ready
    tbpu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // result sequencer and output register
    tbpu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_head     (q_head),
        .o_pop      (q_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule
